FILE: design/b64d_pkg.sv
// Package for the streaming base64 decoder: item kinds, character codes,
// decoder state and result types. No dependencies.
`default_nettype none

package b64d_pkg;

    typedef enum logic [1:0] {
        KIND_DATA       = 2'd0,
        KIND_NEXT_PIECE = 2'd1,
        KIND_STATUS     = 2'd2,
        KIND_NEW_FILE   = 2'd3
    } t_kind;

    localparam int unsigned ACC_W   = 14;
    localparam int unsigned CNT_W   = 4;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned SEXT_W  = 6;

    localparam logic [CNT_W-1:0] CNT_STEP = CNT_W'(SEXT_W);
    localparam logic [CNT_W-1:0] CNT_BYTE = CNT_W'(BYTE_W);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(6);

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic [7:0] LOWER_OFS = 8'd26;
    localparam logic [7:0] DIGIT_OFS = 8'd52;
    localparam logic [SEXT_W-1:0] SEXT_PLUS  = 6'd62;
    localparam logic [SEXT_W-1:0] SEXT_SLASH = 6'd63;

    typedef struct packed {
        logic [ACC_W-1:0] bit_accumulator;
        logic [CNT_W-1:0] bit_count;
        logic             piece_started;
        logic             no_error;
    } t_state;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_out;
        logic              byte_valid;
        logic              status_ok;
    } t_result;

    localparam t_state STATE_RESET = '{
        bit_accumulator: '0,
        bit_count:       '0,
        piece_started:   1'b0,
        no_error:        1'b1
    };

endpackage

`default_nettype wire

FILE: design/b64d_if.sv
// Stream interfaces for the base64 decoder: input item channel and result
// channel, valid/ready handshake. Depends on nothing.
`default_nettype none

interface b64d_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface b64d_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic       byte_valid;
    logic       status_ok;

    modport source (output valid, output byte_out, output byte_valid, output status_ok,
                    input ready);
    modport sink   (input valid, input byte_out, input byte_valid, input status_ok,
                    output ready);
endinterface

`default_nettype wire

FILE: design/b64d_step.sv
// Per-item decode step: next decoder state and result from current state
// and one input item. Depends on b64d_pkg.
`default_nettype none

module b64d_step (
    input  wire b64d_pkg::t_state  i_state,
    input  wire logic [1:0]        i_kind,
    input  wire logic [7:0]        i_data_byte,
    output      b64d_pkg::t_state  o_state,
    output      b64d_pkg::t_result o_result
);
    import b64d_pkg::*;

    logic [7:0]        ofs;
    logic [SEXT_W-1:0] sextet;
    logic              sextet_ok;
    logic              is_space;
    logic [ACC_W-1:0]  acc_shift;
    logic [CNT_W-1:0]  cnt_sum;
    logic [CNT_W-1:0]  cnt_left;
    logic [ACC_W-1:0]  acc_aligned;

    always_comb begin
        ofs       = '0;
        sextet    = '0;
        sextet_ok = 1'b1;
        priority if (i_data_byte >= CH_UPPER_A && i_data_byte <= CH_UPPER_Z) begin
            ofs    = i_data_byte - CH_UPPER_A;
            sextet = ofs[SEXT_W-1:0];
        end else if (i_data_byte >= CH_LOWER_A && i_data_byte <= CH_LOWER_Z) begin
            ofs    = i_data_byte - CH_LOWER_A + LOWER_OFS;
            sextet = ofs[SEXT_W-1:0];
        end else if (i_data_byte >= CH_DIGIT_0 && i_data_byte <= CH_DIGIT_9) begin
            ofs    = i_data_byte - CH_DIGIT_0 + DIGIT_OFS;
            sextet = ofs[SEXT_W-1:0];
        end else if (i_data_byte == CH_PLUS) begin
            sextet = SEXT_PLUS;
        end else if (i_data_byte == CH_SLASH) begin
            sextet = SEXT_SLASH;
        end else begin
            sextet_ok = 1'b0;
        end
    end

    assign is_space    = (i_data_byte == CH_SPACE) || (i_data_byte == CH_CR)
                      || (i_data_byte == CH_LF);
    assign acc_shift   = {i_state.bit_accumulator[ACC_W-SEXT_W-1:0], sextet};
    assign cnt_sum     = i_state.bit_count + CNT_STEP;
    assign cnt_left    = cnt_sum - CNT_BYTE;
    assign acc_aligned = acc_shift >> cnt_left;

    always_comb begin
        o_state             = i_state;
        o_result.byte_out   = '0;
        o_result.byte_valid = 1'b0;
        unique case (i_kind)
            KIND_DATA: begin
                if (!i_state.piece_started) begin
                    if (!is_space) begin
                        o_state.piece_started = 1'b1;
                        if (i_data_byte != CH_QUOTE) begin
                            o_state.no_error = 1'b0;
                        end
                    end
                end else if (i_state.no_error && sextet_ok) begin
                    o_state.bit_accumulator = acc_shift;
                    if (cnt_sum >= CNT_BYTE) begin
                        o_state.bit_count   = cnt_left;
                        o_result.byte_out   = acc_aligned[BYTE_W-1:0];
                        o_result.byte_valid = 1'b1;
                    end else begin
                        o_state.bit_count = cnt_sum;
                    end
                end
            end
            KIND_NEXT_PIECE: begin
                o_state.bit_accumulator = '0;
                o_state.bit_count       = '0;
                o_state.piece_started   = 1'b0;
            end
            KIND_STATUS: begin
                o_state = i_state;
            end
            KIND_NEW_FILE: begin
                o_state = STATE_RESET;
            end
            default: begin
                o_state = i_state;
            end
        endcase
        o_result.status_ok = o_state.no_error && o_state.piece_started;
    end

endmodule

`default_nettype wire

FILE: design/streaming_base64_decoder_top.sv
// Streaming base64 decoder, top level: the result of an accepted item is registered
// and shown on o_out in the cycle after; throughput one item per cycle while o_out.ready is high.
// The result register frees when it is empty or o_out.ready is high, and i_in.ready follows it.
// Synchronous active-low reset returns decoder state to its initial values
// (no error, piece not started) and empties the result register.
// Depends on b64d_pkg, b64d_if and b64d_step.
`default_nettype none

module streaming_base64_decoder_top (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    b64d_in_if.sink    i_in,
    b64d_out_if.source o_out
);
    import b64d_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_result r_result;
    t_result n_result;
    logic    r_out_valid;
    logic    in_fire;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_fire    = i_in.valid && i_in.ready;

    b64d_step u_step (
        .i_state     (r_state),
        .i_kind      (i_in.kind),
        .i_data_byte (i_in.data_byte),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= STATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_state <= n_state;
            end
            if (i_in.ready) begin
                r_out_valid <= i_in.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.byte_out   = r_result.byte_out;
    assign o_out.byte_valid = r_result.byte_valid;
    assign o_out.status_ok  = r_result.status_ok;

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.bit_count <= CNT_MAX)
        else $error("bit count left its range");

    a_byte_implies_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.byte_valid) |-> r_result.status_ok)
        else $error("decoded byte without started, error-free piece");

    a_new_file_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.kind == KIND_NEW_FILE) |=>
        (r_state.no_error && !r_state.piece_started && r_state.bit_count == '0
         && r_out_valid && !r_result.byte_valid))
        else $error("new file did not clear state");

    a_status_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.kind == KIND_STATUS) |=> ($stable(r_state) && r_out_valid))
        else $error("status query changed state");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_out_valid)
        else $error("accepted transaction produced no result");
`endif

endmodule

`default_nettype wire
